@@ rtl/core/per_source_min_max_tracker_unit_defines.svh @@
// Assertion macros shared by the min/max tracker RTL.
// No dependencies; every user must have clk and rst in scope.
`ifndef PER_SOURCE_MIN_MAX_TRACKER_UNIT_DEFINES_SVH
`define PER_SOURCE_MIN_MAX_TRACKER_UNIT_DEFINES_SVH

// same-cycle implication
`define MMT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mmt assertion failed: same-cycle check");

// next-cycle implication
`define MMT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mmt assertion failed: next-cycle check");

`endif

@@ rtl/core/mmt_pkg.sv @@
// Package for the per-source min/max tracker: widths, defaults, token type.
// No dependencies.
package mmt_pkg;

  localparam int ADDR_W          = 32;
  localparam int RTT_W           = 32;
  localparam int COUNT_W         = 7;
  localparam int MAX_SENDERS_DEF = 64;

  // token that walks the cell row, one cell per cycle
  // lookup pass: addr/rtt are the sample; scan pass: running best
  typedef struct packed {
    logic              active;
    logic              scan;
    logic [ADDR_W-1:0] addr;
    logic [RTT_W-1:0]  rtt;
    logic              found;
    logic              lowered;
    logic              taken;
  } tok_t;

endpackage

@@ rtl/core/mmt_cell.sv @@
// One table slot of the tracker: sender address and its minimum round trip.
// Depends on mmt_pkg (tok_t).
module mmt_cell import mmt_pkg::*; #(
  parameter int IDX  = 0,
  parameter int CNTW = 7
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CNTW-1:0] count,
  input  tok_t            tok_in,
  output tok_t            tok_out
);

  localparam logic [CNTW-1:0] MY_IDX = CNTW'(IDX);

  logic [ADDR_W-1:0] entry_addr;
  logic [RTT_W-1:0]  entry_min;
  tok_t              tok_next;
  logic              valid;
  logic              is_slot;
  logic              ins;
  logic              lower;

  assign valid   = MY_IDX < count;
  assign is_slot = MY_IDX == count;

  // lookup: match/lower or insert at the first free slot; scan: best update
  always_comb begin
    tok_next = tok_in;
    ins      = 1'b0;
    lower    = 1'b0;
    if (tok_in.active) begin
      if (!tok_in.scan) begin
        if (valid && !tok_in.found && entry_addr == tok_in.addr) begin
          tok_next.found = 1'b1;
          if (tok_in.rtt < entry_min) begin
            lower            = 1'b1;
            tok_next.lowered = 1'b1;
          end
        end else if (is_slot && !tok_in.found) begin
          ins = 1'b1;
        end
      end else if (valid && (entry_min > tok_in.rtt ||
                   (tok_in.taken && entry_min == tok_in.rtt &&
                    entry_addr < tok_in.addr))) begin
        tok_next.addr  = entry_addr;
        tok_next.rtt   = entry_min;
        tok_next.taken = 1'b1;
      end
    end
  end

  // slot storage, written on insert or lower
  always_ff @(posedge clk) begin
    if (ins) begin
      entry_addr <= tok_in.addr;
      entry_min  <= tok_in.rtt;
    end else if (lower) begin
      entry_min  <= tok_in.rtt;
    end
  end

  // hand token to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.active <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

@@ rtl/core/mmt_chain.sv @@
// Row of tracker cells; the token enters at head and leaves at tail.
// Depends on mmt_pkg and mmt_cell.
module mmt_chain import mmt_pkg::*; #(
  parameter int MAX_SENDERS = MAX_SENDERS_DEF,
  parameter int CNTW        = $clog2(MAX_SENDERS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [CNTW-1:0] count,
  input  tok_t            head,
  output tok_t            tail
);

  tok_t link [0:MAX_SENDERS];

  assign link[0] = head;
  assign tail    = link[MAX_SENDERS];

  for (genvar i = 0; i < MAX_SENDERS; i++) begin : g_cell
    mmt_cell #(
      .IDX  (i),
      .CNTW (CNTW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .count   (count),
      .tok_in  (link[i]),
      .tok_out (link[i+1])
    );
  end

endmodule

@@ rtl/core/per_source_min_max_tracker_unit.sv @@
// Per-source min/max tracker. Each sample sends the token once through the cell row;
// when the top sender's minimum drops, the token walks the cell row a second time
// for the rescan before the result is taken.
// Only one sample is in flight at a time; busy falls as done rises, so a new transfer
// can be taken once done rises. The receiver cannot stall.
// Synchronous reset empties the table and clears top sender and top rtt.
`include "per_source_min_max_tracker_unit_defines.svh"
module per_source_min_max_tracker_unit import mmt_pkg::*; #(
  parameter int MAX_SENDERS = MAX_SENDERS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [ADDR_W-1:0]  sender_addr,
  input  logic [RTT_W-1:0]   rtt_sample,
  output logic               done,
  output logic [ADDR_W-1:0]  max_sender,
  output logic [RTT_W-1:0]   max_min_rtt,
  output logic               dropped,
  output logic [COUNT_W-1:0] sender_count
);

  localparam int              CNTW = $clog2(MAX_SENDERS + 1);
  localparam logic [CNTW-1:0] FULL = CNTW'(MAX_SENDERS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN
  } state_t;

  state_t            state;
  tok_t              launch;
  tok_t              tail;
  logic [CNTW-1:0]   count;
  logic [ADDR_W-1:0] top_sender;
  logic [RTT_W-1:0]  top_rtt;
  logic [ADDR_W-1:0] cur_addr;
  logic [RTT_W-1:0]  cur_rtt;

  assign busy         = state != ST_IDLE;
  assign max_sender   = top_sender;
  assign max_min_rtt  = top_rtt;
  assign sender_count = COUNT_W'(count);

  mmt_chain #(
    .MAX_SENDERS (MAX_SENDERS),
    .CNTW        (CNTW)
  ) u_chain (
    .clk   (clk),
    .rst   (rst),
    .count (count),
    .head  (launch),
    .tail  (tail)
  );

  // sequencer: launch lookup, decide at tail, optional rescan pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      launch     <= '0;
      count      <= '0;
      top_sender <= '0;
      top_rtt    <= '0;
      done       <= 1'b0;
      dropped    <= 1'b0;
    end else begin
      launch.active <= 1'b0;
      done          <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cur_addr <= sender_addr;
            cur_rtt  <= rtt_sample;
            launch   <= '{active: 1'b1, scan: 1'b0, addr: sender_addr,
                          rtt: rtt_sample, found: 1'b0, lowered: 1'b0,
                          taken: 1'b0};
            state    <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          if (tail.active) begin
            if (!tail.found) begin
              if (count < FULL) begin
                count   <= count + 1'b1;
                dropped <= 1'b0;
                if (cur_rtt > top_rtt) begin
                  top_sender <= cur_addr;
                  top_rtt    <= cur_rtt;
                end
              end else begin
                dropped <= 1'b1;
              end
              done  <= 1'b1;
              state <= ST_IDLE;
            end else if (tail.lowered && cur_addr == top_sender) begin
              top_rtt <= cur_rtt;
              launch  <= '{active: 1'b1, scan: 1'b1, addr: top_sender,
                           rtt: cur_rtt, found: 1'b0, lowered: 1'b0,
                           taken: 1'b0};
              state   <= ST_SCAN;
            end else begin
              dropped <= 1'b0;
              done    <= 1'b1;
              state   <= ST_IDLE;
            end
          end
        end
        ST_SCAN: begin
          if (tail.active) begin
            top_sender <= tail.addr;
            top_rtt    <= tail.rtt;
            dropped    <= 1'b0;
            done       <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a token only comes back while a sample is in progress
  `MMT_ASSERT_NOW(a_tail_while_busy, tail.active, busy)
  // result strobe coincides with a free command port
  `MMT_ASSERT_NOW(a_done_idle, done, !busy)
  // accepted transfer starts a walk
  `MMT_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  // one strobe per sample
  `MMT_ASSERT_NEXT(a_done_single, done, !done)
  // fill count never passes the table depth
  `MMT_ASSERT_NOW(a_count_bound, 1'b1, count <= FULL)

endmodule
